// ===== rtl/tmf_pkg.sv =====
// Shared types and constants of the dataflow token matching and firing unit.
package tmf_pkg;

	localparam int FN_W       = 3;
	localparam int SLOT_W     = 3;
	localparam int MASK_W     = 8;
	localparam int PEND_W     = 5;
	localparam int STATUS_W   = 2;
	localparam int CFG_W      = 32;
	localparam int ARITY_W    = 4;
	localparam int MAX_INPUTS = 8;

	localparam int IN_TDATA_W   = 8;
	localparam int OUT_TDATA_W  = 8;
	localparam int OUT_TUSER_W  = 3;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SLOT = 2'd2;

	typedef struct packed {
		logic                fire;
		logic [FN_W-1:0]     fired_fn;
		logic [STATUS_W-1:0] status;
		logic [PEND_W-1:0]   pending;
	} tmf_result_t;

endpackage

// ===== rtl/dataflow_token_match_fire.sv =====
// Top level of the dataflow token matching and firing unit.
//
//  channel      dir  handshake                    contents
//  s_axis       in   s_axis_tvalid/s_axis_tready  tdata: fn_id[2:0], slot[5:3]
//  m_axis       out  m_axis_tvalid/m_axis_tready  tdata: fired_fn, pending; tuser: fire, status
//  cfg          in   cfg_we                       cfg_wdata: arity_table
//
// From one accepted token to the next, when the mask is appended behind the queued
// masks: a read fill step, one compare per mask from the single read port of the mask
// memory, then append, finish, done and idle; done waits until the word is taken. A
// merge ends the scan early and goes to finish; a full queue skips append and an
// empty queue skips the scan. Tokens with a bad function or slot go straight to done.
// Reset clears the queue pointers and counts at once; no clearing pass runs.
// A finished word waits in the output register while the next token is taken.
module dataflow_token_match_fire #(
	parameter int NUM_FUNCS   = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [tmf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // fn_id[2:0], slot[5:3]
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [tmf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // fired_fn[2:0], pending[7:3]
	output logic [tmf_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,  // fire[0], status[2:1]
	input  logic                               cfg_we,
	input  logic [tmf_pkg::CFG_W-1:0]          cfg_wdata
);
	import tmf_pkg::*;

	localparam int DEPTH = NUM_FUNCS * QUEUE_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CFG_W-1:0]  arity_q;
	logic              res_valid;
	logic              res_take;
	tmf_result_t       res;
	tmf_result_t       out_q;
	logic              out_vld_q;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [MASK_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [MASK_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arity_q <= '0;
		end else if (cfg_we) begin
			arity_q <= cfg_wdata;
		end
	end

	tmf_seq #(
		.NUM_FUNCS  (NUM_FUNCS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.AW         (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.arity_table(arity_q),
		.tok_valid  (s_axis_tvalid),
		.tok_fn     (s_axis_tdata[FN_W-1:0]),
		.tok_slot   (s_axis_tdata[FN_W +: SLOT_W]),
		.tok_ready  (s_axis_tready),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	tmf_mask_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// load the output word when the register is empty or being drained
	assign res_take = res_valid && (!out_vld_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_take) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_q.pending, out_q.fired_fn};
	assign m_axis_tuser  = {out_q.status, out_q.fire};

endmodule

// ===== rtl/tmf_mask_ram.sv =====
// Ready-mask memory: one write port, one read port with registered read data.
module tmf_mask_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [tmf_pkg::MASK_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [tmf_pkg::MASK_W-1:0] rdata
);
	import tmf_pkg::*;

	logic [MASK_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tmf_seq.sv =====
// Token sequencer: per-function queue pointers and the mask scan and update loop.
module tmf_seq #(
	parameter int NUM_FUNCS   = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int AW          = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tmf_pkg::CFG_W-1:0]   arity_table,
	input  logic                        tok_valid,
	input  logic [tmf_pkg::FN_W-1:0]    tok_fn,
	input  logic [tmf_pkg::SLOT_W-1:0]  tok_slot,
	output logic                        tok_ready,
	output logic                        res_valid,
	input  logic                        res_take,
	output tmf_pkg::tmf_result_t        res,
	output logic                        ram_we,
	output logic [AW-1:0]               ram_waddr,
	output logic [tmf_pkg::MASK_W-1:0]  ram_wdata,
	output logic [AW-1:0]               ram_raddr,
	input  logic [tmf_pkg::MASK_W-1:0]  ram_rdata
);
	import tmf_pkg::*;

	localparam int FIDX_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
	localparam int HW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_APPEND = 3'd2;
	localparam logic [2:0] S_FIN    = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]        state_q;
	logic [HW-1:0]     head_arr_q [NUM_FUNCS];
	logic [CW-1:0]     cnt_arr_q  [NUM_FUNCS];

	logic [FIDX_W-1:0] fidx_q;
	logic [AW-1:0]     base_q;
	logic [MASK_W-1:0] bit_q;
	logic [MASK_W-1:0] full_q;
	logic [HW-1:0]     head_q;
	logic [CW-1:0]     cnt_q;
	logic [HW-1:0]     pos_q;
	logic [CW-1:0]     issue_q;
	logic              cmp_vld_q;
	logic [CW-1:0]     cmp_idx_q;
	logic [HW-1:0]     cmp_pos_q;
	logic [MASK_W-1:0] head_mask_q;
	tmf_result_t       res_q;

	// token decode
	logic [FIDX_W-1:0]  in_fidx;
	logic [ARITY_W-1:0] nib;
	logic [ARITY_W-1:0] arity;
	logic [MASK_W:0]    full_w;
	logic               fn_bad;
	logic               slot_bad;
	logic [AW-1:0]      in_base;

	// shared compare unit
	logic [MASK_W-1:0]  merged;
	logic               hit;
	logic               cmp_last;
	logic [HW-1:0]      pos_nxt;
	logic [HW-1:0]      head_inc;

	function automatic logic [PEND_W-1:0] pend_of(input logic [CW-1:0] c);
		logic [CW+PEND_W-1:0] ext;
		ext = {{PEND_W{1'b0}}, c};
		return ext[PEND_W-1:0];
	endfunction

	assign in_fidx  = tok_fn[FIDX_W-1:0];
	assign nib      = arity_table[{tok_fn, 2'b00} +: ARITY_W];
	assign arity    = (nib >= ARITY_W'(MAX_INPUTS - 1)) ? ARITY_W'(MAX_INPUTS)
	                                                    : nib + ARITY_W'(1);
	assign full_w   = ((MASK_W+1)'(1) << arity) - (MASK_W+1)'(1);
	assign fn_bad   = {1'b0, tok_fn} >= (FN_W+1)'(NUM_FUNCS);
	assign slot_bad = {1'b0, tok_slot} >= arity;
	assign in_base  = AW'(in_fidx) * AW'(QUEUE_DEPTH);

	assign merged   = ram_rdata | bit_q;
	assign hit      = cmp_vld_q && ((ram_rdata & bit_q) == '0);
	assign cmp_last = (cmp_idx_q == cnt_q - CW'(1));
	assign pos_nxt  = (pos_q == HW'(QUEUE_DEPTH - 1)) ? '0 : pos_q + HW'(1);
	assign head_inc = (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q + HW'(1);

	assign tok_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;
	assign ram_raddr = base_q + AW'(pos_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = base_q + AW'(pos_q);
		ram_wdata = bit_q;
		if (state_q == S_SCAN && hit) begin
			ram_we    = 1'b1;
			ram_waddr = base_q + AW'(cmp_pos_q);
			ram_wdata = merged;
		end else if (state_q == S_APPEND) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cmp_vld_q <= 1'b0;
			for (int k = 0; k < NUM_FUNCS; k++) begin
				head_arr_q[k] <= '0;
				cnt_arr_q[k]  <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cmp_vld_q <= 1'b0;
					if (tok_valid) begin
						if (fn_bad || slot_bad) begin
							state_q <= S_DONE;
						end else if (cnt_arr_q[in_fidx] == '0) begin
							state_q <= S_APPEND;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					cmp_vld_q <= (issue_q < cnt_q);
					if (hit) begin
						state_q   <= S_FIN;
						cmp_vld_q <= 1'b0;
					end else if (cmp_vld_q && cmp_last) begin
						state_q   <= (cnt_q == CW'(QUEUE_DEPTH)) ? S_DONE : S_APPEND;
						cmp_vld_q <= 1'b0;
					end
				end
				S_APPEND: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_DONE;
					if (head_mask_q == full_q) begin
						head_arr_q[fidx_q] <= head_inc;
						cnt_arr_q[fidx_q]  <= cnt_q - CW'(1);
					end else begin
						head_arr_q[fidx_q] <= head_q;
						cnt_arr_q[fidx_q]  <= cnt_q;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (tok_valid) begin
					fidx_q  <= in_fidx;
					base_q  <= in_base;
					bit_q   <= MASK_W'(1) << tok_slot;
					full_q  <= full_w[MASK_W-1:0];
					head_q  <= head_arr_q[in_fidx];
					cnt_q   <= cnt_arr_q[in_fidx];
					pos_q   <= head_arr_q[in_fidx];
					issue_q <= '0;
					res_q.fire     <= 1'b0;
					res_q.fired_fn <= tok_fn;
					res_q.status   <= ST_SLOT;
					res_q.pending  <= fn_bad ? '0 : pend_of(cnt_arr_q[in_fidx]);
				end
			end
			S_SCAN: begin
				if (issue_q < cnt_q && !hit && !(cmp_vld_q && cmp_last)) begin
					cmp_idx_q <= issue_q;
					cmp_pos_q <= pos_q;
					pos_q     <= pos_nxt;
					issue_q   <= issue_q + CW'(1);
				end
				if (cmp_vld_q && cmp_idx_q == '0) begin
					head_mask_q <= hit ? merged : ram_rdata;
				end
				if (cmp_vld_q && !hit && cmp_last) begin
					// every queued mask already holds the bit; full queue drops it
					res_q.status  <= ST_FULL;
					res_q.pending <= pend_of(cnt_q);
				end
			end
			S_APPEND: begin
				if (cnt_q == '0) begin
					head_mask_q <= bit_q;
				end
				cnt_q <= cnt_q + CW'(1);
			end
			S_FIN: begin
				res_q.status <= ST_OK;
				if (head_mask_q == full_q) begin
					res_q.fire    <= 1'b1;
					res_q.pending <= pend_of(cnt_q - CW'(1));
				end else begin
					res_q.fire    <= 1'b0;
					res_q.pending <= pend_of(cnt_q);
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule
